/* rtl/epmc_pkg.sv */
// ----------------------------------------------------------------------------
// Entity pool package
// Shared constants, operation and status codes, and transfer payload types.
// ----------------------------------------------------------------------------
package epmc_pkg;

  localparam int ENTITY_SLOTS_DEF    = 64;
  localparam int COMPONENT_KINDS_DEF = 32;
  localparam int RESULT_LIMIT        = 64;
  localparam int HIT_CNT_W           = $clog2(RESULT_LIMIT + 1);

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_TEST   = 3'd4;
  localparam logic [2:0] OP_VALID  = 3'd5;
  localparam logic [2:0] OP_MATCH  = 3'd6;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  entity_index;
    logic [4:0]  component_index;
    logic [31:0] query_mask;
    logic [6:0]  create_count;
  } in_item_t;

  typedef struct packed {
    logic [5:0] result_id;
    logic       answer_bit;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

endpackage

/* rtl/epmc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module epmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/epmc_out.sv */
// ----------------------------------------------------------------------------
// Result output register
// Holds one result until its transfer completes and reports when it can take
// a new one.
// ----------------------------------------------------------------------------
module epmc_out import epmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/entity_id_pool_with_component_masks_unit.sv */
// ----------------------------------------------------------------------------
// Entity ID pool with component masks
// Hands out entity IDs from a freed-ID queue and a high-water mark, and keeps
// a component mask and a valid bit per entity in a RAM.
//
//   Port group   Direction   Handshake             Payload
//   in_*         input       in_valid / in_ready   in_item_t
//   out_*        output      out_valid / out_ready out_item_t
//
// Delete, add, remove, test and test-valid do one RAM read and then answer
// and write back. Create hands out one ID per step, and a create that does
// not fit the pool or asks for more than 64 IDs answers with one full status.
// Match scans the slots in order and ends at the high-water mark or at the
// 64th match. A stalled output holds back each result until the output
// register is free. Reset is immediate: entries are trusted only below the
// high-water mark, so no clearing pass runs.
// ----------------------------------------------------------------------------
module entity_id_pool_with_component_masks_unit import epmc_pkg::*; #(
  parameter int ENTITY_SLOTS    = ENTITY_SLOTS_DEF,
  parameter int COMPONENT_KINDS = COMPONENT_KINDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW  = $clog2(ENTITY_SLOTS);
  localparam int HWW = $clog2(ENTITY_SLOTS + 1);
  localparam int PW  = HWW + 1;
  localparam int XW  = (HWW > 6) ? HWW : 6;
  localparam int RW  = (HWW + 1 > 7) ? HWW + 1 : 7;
  localparam int MW  = COMPONENT_KINDS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_CREATE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  in_item_t               item_r, item_nxt;
  logic [HWW-1:0]         hw_r, hw_nxt;
  logic [HWW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [6:0]             cnt_r, cnt_nxt;
  logic [HWW-1:0]         scan_r, scan_nxt;
  logic [HIT_CNT_W-1:0]   hits_r, hits_nxt;
  logic [AW-1:0]          pend_id_r, pend_id_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  out_item_t              res_r, res_nxt;

  logic                   m_we;
  logic [AW-1:0]          m_waddr;
  logic [MW-1:0]          m_wdata;
  logic [AW-1:0]          m_raddr;
  logic [MW-1:0]          m_rdata;
  logic                   f_we;
  logic [AW-1:0]          f_waddr;
  logic [AW-1:0]          f_wdata;
  logic [AW-1:0]          f_raddr;
  logic [AW-1:0]          f_rdata;

  logic                   push;
  out_item_t              push_item;
  logic                   slot_free;

  logic [RW-1:0]          room;
  logic [PW-1:0]          psum;
  logic [AW-1:0]          head_inc;
  logic [COMPONENT_KINDS-1:0] cur_mask;
  logic [COMPONENT_KINDS-1:0] comp_bit;
  logic                   comp_ok;
  logic                   live;
  logic [31:0]            mask32;
  logic                   scan_hit;
  logic                   scan_done;
  logic [AW-1:0]          new_id;

  epmc_ram #(
    .WIDTH(MW),
    .DEPTH(ENTITY_SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .raddr(m_raddr),
    .rdata(m_rdata)
  );

  epmc_ram #(
    .WIDTH(AW),
    .DEPTH(ENTITY_SLOTS)
  ) u_free_ram (
    .clk  (clk),
    .we   (f_we),
    .waddr(f_waddr),
    .wdata(f_wdata),
    .raddr(f_raddr),
    .rdata(f_rdata)
  );

  epmc_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .slot_free(slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign in_ready = (state_r == S_IDLE);

  assign room     = RW'(fill_r) + RW'(ENTITY_SLOTS) - RW'(hw_r);
  assign psum     = PW'(head_r) + PW'(fill_r);
  assign f_waddr  = (psum >= PW'(ENTITY_SLOTS)) ? AW'(psum - PW'(ENTITY_SLOTS)) : AW'(psum);
  assign f_wdata  = AW'(item_r.entity_index);
  assign head_inc = (head_r == AW'(ENTITY_SLOTS - 1)) ? '0 : head_r + AW'(1);

  assign cur_mask = m_rdata[COMPONENT_KINDS-1:0];
  assign comp_bit = COMPONENT_KINDS'(1) << item_r.component_index;
  assign comp_ok  = ({2'b00, item_r.component_index} < 7'(COMPONENT_KINDS));
  assign live     = (XW'(item_r.entity_index) < XW'(hw_r)) && m_rdata[COMPONENT_KINDS];

  assign mask32    = 32'(cur_mask);
  assign scan_hit  = m_rdata[COMPONENT_KINDS] &&
                     ((mask32 & item_r.query_mask) == item_r.query_mask);
  assign scan_done = (scan_r >= hw_r) || (hits_r == HIT_CNT_W'(RESULT_LIMIT));
  assign new_id    = (fill_r != '0) ? f_rdata : AW'(hw_r);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    hw_nxt       = hw_r;
    fill_nxt     = fill_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    scan_nxt     = scan_r;
    hits_nxt     = hits_r;
    pend_id_nxt  = pend_id_r;
    pend_vld_nxt = pend_vld_r;
    res_nxt      = res_r;
    m_we         = 1'b0;
    m_waddr      = AW'(item_r.entity_index);
    m_wdata      = '0;
    m_raddr      = '0;
    f_we         = 1'b0;
    push         = 1'b0;
    push_item    = res_r;

    case (state_r)
      S_IDLE: begin
        m_raddr = (in_data.opcode == OP_MATCH) ? '0 : AW'(in_data.entity_index);
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.opcode)
            OP_CREATE: begin
              if (in_data.create_count != 7'd0) begin
                if ((RW'(in_data.create_count) > room) ||
                    (in_data.create_count > 7'(RESULT_LIMIT))) begin
                  res_nxt   = '{result_id: 6'd0, answer_bit: 1'b0,
                                status: STATUS_FULL, last_of_run: 1'b1};
                  state_nxt = S_EMIT;
                end else begin
                  cnt_nxt   = in_data.create_count;
                  state_nxt = S_CREATE;
                end
              end
            end
            OP_DELETE, OP_ADD, OP_REMOVE, OP_TEST, OP_VALID: begin
              state_nxt = S_ACCESS;
            end
            OP_MATCH: begin
              scan_nxt     = '0;
              hits_nxt     = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_ACCESS: begin
        m_raddr = AW'(item_r.entity_index);
        if (slot_free) begin
          push      = 1'b1;
          push_item = '{result_id: item_r.entity_index, answer_bit: 1'b0,
                        status: STATUS_OK, last_of_run: 1'b1};
          state_nxt = S_IDLE;
          if (item_r.opcode == OP_VALID) begin
            push_item.answer_bit = live;
          end else if (!live) begin
            push_item.status = STATUS_INVALID;
          end else if (item_r.opcode == OP_DELETE) begin
            m_we = 1'b1;
            if (fill_r < HWW'(ENTITY_SLOTS)) begin
              f_we     = 1'b1;
              fill_nxt = fill_r + HWW'(1);
            end
          end else if (comp_ok) begin
            case (item_r.opcode)
              OP_ADD: begin
                m_we    = 1'b1;
                m_wdata = {1'b1, cur_mask | comp_bit};
              end
              OP_REMOVE: begin
                m_we    = 1'b1;
                m_wdata = {1'b1, cur_mask & ~comp_bit};
              end
              default: begin
                push_item.answer_bit = |(cur_mask & comp_bit);
              end
            endcase
          end
        end
      end

      S_CREATE: begin
        if (slot_free) begin
          push      = 1'b1;
          push_item = '{result_id: 6'(new_id), answer_bit: 1'b1,
                        status: STATUS_OK, last_of_run: (cnt_r == 7'd1)};
          m_we      = 1'b1;
          m_waddr   = new_id;
          m_wdata   = {1'b1, {COMPONENT_KINDS{1'b0}}};
          if (fill_r != '0) begin
            head_nxt = head_inc;
            fill_nxt = fill_r - HWW'(1);
          end else begin
            hw_nxt = hw_r + HWW'(1);
          end
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        if (scan_done) begin
          if (pend_vld_r) begin
            res_nxt = '{result_id: 6'(pend_id_r), answer_bit: 1'b1,
                        status: STATUS_OK, last_of_run: 1'b1};
          end else begin
            res_nxt = '{result_id: 6'd0, answer_bit: 1'b0,
                        status: STATUS_OK, last_of_run: 1'b1};
          end
          state_nxt = S_EMIT;
        end else if (scan_hit) begin
          if (!pend_vld_r) begin
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = AW'(scan_r);
            hits_nxt     = hits_r + HIT_CNT_W'(1);
            scan_nxt     = scan_r + HWW'(1);
          end else if (slot_free) begin
            push         = 1'b1;
            push_item    = '{result_id: 6'(pend_id_r), answer_bit: 1'b1,
                             status: STATUS_OK, last_of_run: 1'b0};
            pend_id_nxt  = AW'(scan_r);
            hits_nxt     = hits_r + HIT_CNT_W'(1);
            scan_nxt     = scan_r + HWW'(1);
          end
        end else begin
          scan_nxt = scan_r + HWW'(1);
        end
        m_raddr = AW'(scan_nxt);
      end

      S_EMIT: begin
        if (slot_free) begin
          push      = 1'b1;
          push_item = res_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    f_raddr = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      hw_r       <= '0;
      fill_r     <= '0;
      head_r     <= '0;
      cnt_r      <= '0;
      scan_r     <= '0;
      hits_r     <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hw_r       <= hw_nxt;
      fill_r     <= fill_nxt;
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      scan_r     <= scan_nxt;
      hits_r     <= hits_nxt;
      pend_vld_r <= pend_vld_nxt;
      item_r     <= item_nxt;
      pend_id_r  <= pend_id_nxt;
      res_r      <= res_nxt;
    end
  end

  // The freed-ID queue only ever holds IDs that were handed out earlier.
  a_fill_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= hw_r)
    else $error("freed ID count exceeds high-water mark");

  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= HWW'(ENTITY_SLOTS))
    else $error("high-water mark beyond pool size");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free)
    else $error("result pushed into a full output register");

  a_create_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CREATE && push && cnt_r == 7'd1) |=> (state_r == S_IDLE))
    else $error("create run did not end after its last ID");

endmodule
